### hdl/lsr_pkg.sv
// shared types and constants for the line segment rasterizer
package lsr_pkg;

   localparam int COORD_W = 6;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_DRAW_LEVEL   = 2'd2;

   typedef struct packed {
      logic [COORD_W-1:0]      maj0;
      logic [COORD_W-1:0]      min0;
      logic [COORD_W-1:0]      dmaj;
      logic signed [COORD_W:0] dmin;
      logic                    step_col;
   } seg_type;

   typedef struct packed {
      logic    push;
      seg_type data;
   } push_type;

   typedef struct packed {
      logic    valid;
      seg_type data;
   } head_type;

endpackage

### hdl/lsr_front.sv
// front end: range check and major/minor axis classification of a segment
module lsr_front #(
   parameter int MAX_DIM = 64
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [7:0] req_start_col,
   input  logic signed [7:0] req_start_row,
   input  logic signed [7:0] req_end_col,
   input  logic signed [7:0] req_end_row,
   input  logic [6:0]        image_width,
   input  logic [6:0]        image_height,
   input  logic              queue_full,
   output lsr_pkg::push_type push
);

   logic [6:0]        lim_col;
   logic [6:0]        lim_row;
   logic              in_range;
   logic signed [7:0] dc;
   logic signed [7:0] dr;
   logic [7:0]        adc;
   logic [7:0]        adr;
   logic signed [7:0] ndc;
   logic signed [7:0] ndr;

   assign lim_col = (image_width  > 7'(MAX_DIM)) ? 7'(MAX_DIM) : image_width;
   assign lim_row = (image_height > 7'(MAX_DIM)) ? 7'(MAX_DIM) : image_height;

   assign in_range = !req_start_col[7] && (req_start_col[6:0] < lim_col) &&
                     !req_end_col[7]   && (req_end_col[6:0]   < lim_col) &&
                     !req_start_row[7] && (req_start_row[6:0] < lim_row) &&
                     !req_end_row[7]   && (req_end_row[6:0]   < lim_row);

   assign dc  = req_end_col - req_start_col;
   assign dr  = req_end_row - req_start_row;
   assign ndc = -dc;
   assign ndr = -dr;
   assign adc = dc[7] ? ndc : dc;
   assign adr = dr[7] ? ndr : dr;

   assign req_stall = queue_full;

   always_comb begin
      push.push          = req_valid && !queue_full && in_range;
      push.data.step_col = (adr <= adc);
      if (adr <= adc) begin
         push.data.dmaj = adc[lsr_pkg::COORD_W-1:0];
         if (!dc[7]) begin
            push.data.maj0 = req_start_col[lsr_pkg::COORD_W-1:0];
            push.data.min0 = req_start_row[lsr_pkg::COORD_W-1:0];
            push.data.dmin = dr[lsr_pkg::COORD_W:0];
         end else begin
            push.data.maj0 = req_end_col[lsr_pkg::COORD_W-1:0];
            push.data.min0 = req_end_row[lsr_pkg::COORD_W-1:0];
            push.data.dmin = ndr[lsr_pkg::COORD_W:0];
         end
      end else begin
         push.data.dmaj = adr[lsr_pkg::COORD_W-1:0];
         if (!dr[7]) begin
            push.data.maj0 = req_start_row[lsr_pkg::COORD_W-1:0];
            push.data.min0 = req_start_col[lsr_pkg::COORD_W-1:0];
            push.data.dmin = dc[lsr_pkg::COORD_W:0];
         end else begin
            push.data.maj0 = req_end_row[lsr_pkg::COORD_W-1:0];
            push.data.min0 = req_end_col[lsr_pkg::COORD_W-1:0];
            push.data.dmin = ndc[lsr_pkg::COORD_W:0];
         end
      end
   end

endmodule

### hdl/lsr_queue.sv
// two-entry segment queue between front end and stepper
module lsr_queue (
   input  logic              clock,
   input  logic              reset,
   input  lsr_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output lsr_pkg::head_type head
);

   lsr_pkg::seg_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.data  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push.push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/lsr_back.sv
// back end: incremental rational stepper with registered pixel output
module lsr_back (
   input  logic              clock,
   input  logic              reset,
   input  lsr_pkg::head_type head,
   output logic              pop,
   input  logic [7:0]        draw_level,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [5:0]        rsp_pixel_col,
   output logic [5:0]        rsp_pixel_row,
   output logic [7:0]        rsp_pixel_level,
   output logic              rsp_last_pixel
);

   localparam int CW = lsr_pkg::COORD_W;

   logic              active_ff,   active_in;
   logic [CW-1:0]     major_ff,    major_in;
   logic [CW-1:0]     minor_ff,    minor_in;
   logic [CW-1:0]     remain_ff,   remain_in;
   logic signed [9:0] resid_ff,    resid_in;
   logic [CW:0]       den_ff,      den_in;
   logic signed [7:0] two_dmin_ff, two_dmin_in;
   logic              step_col_ff, step_col_in;
   logic              valid_ff,    valid_in;
   logic [CW-1:0]     col_ff,      col_in;
   logic [CW-1:0]     row_ff,      row_in;
   logic [7:0]        level_ff,    level_in;
   logic              last_ff,     last_in;
   logic              can_out;
   logic signed [9:0] resid_sum;
   logic signed [9:0] den_s;

   assign can_out   = !valid_ff || !rsp_stall;
   assign den_s     = signed'({3'b000, den_ff});
   assign resid_sum = resid_ff + 10'(two_dmin_ff);
   assign pop       = !active_ff;

   always_comb begin
      active_in   = active_ff;
      major_in    = major_ff;
      minor_in    = minor_ff;
      remain_in   = remain_ff;
      resid_in    = resid_ff;
      den_in      = den_ff;
      two_dmin_in = two_dmin_ff;
      step_col_in = step_col_ff;
      valid_in    = valid_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      level_in    = level_ff;
      last_in     = last_ff;
      if (can_out) begin
         valid_in = 1'b0;
      end
      if (active_ff && can_out) begin
         valid_in  = 1'b1;
         col_in    = step_col_ff ? major_ff : minor_ff;
         row_in    = step_col_ff ? minor_ff : major_ff;
         level_in  = draw_level;
         last_in   = (remain_ff == '0);
         major_in  = major_ff + 1'b1;
         remain_in = remain_ff - 1'b1;
         if (remain_ff == '0) begin
            active_in = 1'b0;
         end
         if (resid_sum >= den_s) begin
            minor_in = minor_ff + 1'b1;
            resid_in = resid_sum - den_s;
         end else if (resid_sum < 0) begin
            minor_in = minor_ff - 1'b1;
            resid_in = resid_sum + den_s;
         end else begin
            resid_in = resid_sum;
         end
      end
      if (!active_ff && head.valid) begin
         active_in   = 1'b1;
         major_in    = head.data.maj0;
         minor_in    = head.data.min0;
         remain_in   = head.data.dmaj;
         resid_in    = signed'({4'b0000, head.data.dmaj});
         den_in      = {head.data.dmaj, 1'b0};
         two_dmin_in = {head.data.dmin, 1'b0};
         step_col_in = head.data.step_col;
      end
   end

   always_ff @(posedge clock) begin
      major_ff    <= major_in;
      minor_ff    <= minor_in;
      remain_ff   <= remain_in;
      resid_ff    <= resid_in;
      den_ff      <= den_in;
      two_dmin_ff <= two_dmin_in;
      step_col_ff <= step_col_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      level_ff    <= level_in;
      last_ff     <= last_in;
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_col   = col_ff;
   assign rsp_pixel_row   = row_ff;
   assign rsp_pixel_level = level_ff;
   assign rsp_last_pixel  = last_ff;

endmodule

### hdl/line_segment_rasterizer_core.sv
// line segment rasterizer top level: register port, front end, queue, stepper
// an accepted segment goes into the queue, then into the stepper once it is idle;
// its pixels leave through the output register, one pixel a cycle while rsp_stall
//   is low; each segment takes a load step first; out-of-image segments make no pixels
// reset clears queue and stepper and sets width 64, height 64, level 255
module line_segment_rasterizer_core #(
   parameter int MAX_DIM = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lsr_pkg::ADDR_W-1:0]   paddr,
   input  logic [lsr_pkg::DATA_W-1:0]   pwdata,
   output logic [lsr_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [7:0]            req_start_col,
   input  logic signed [7:0]            req_start_row,
   input  logic signed [7:0]            req_end_col,
   input  logic signed [7:0]            req_end_row,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [5:0]                   rsp_pixel_col,
   output logic [5:0]                   rsp_pixel_row,
   output logic [7:0]                   rsp_pixel_level,
   output logic                         rsp_last_pixel
);

   logic [6:0] image_width_ff,  image_width_in;
   logic [6:0] image_height_ff, image_height_in;
   logic [7:0] draw_level_ff,   draw_level_in;
   logic       csr_write;
   logic [1:0] csr_index;

   lsr_pkg::push_type push;
   lsr_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      draw_level_in   = draw_level_ff;
      if (csr_write) begin
         case (csr_index)
            lsr_pkg::REG_IMAGE_WIDTH:  image_width_in  = pwdata[6:0];
            lsr_pkg::REG_IMAGE_HEIGHT: image_height_in = pwdata[6:0];
            lsr_pkg::REG_DRAW_LEVEL:   draw_level_in   = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         lsr_pkg::REG_IMAGE_WIDTH:  prdata = {25'd0, image_width_ff};
         lsr_pkg::REG_IMAGE_HEIGHT: prdata = {25'd0, image_height_ff};
         lsr_pkg::REG_DRAW_LEVEL:   prdata = {24'd0, draw_level_ff};
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 7'd64;
         image_height_ff <= 7'd64;
         draw_level_ff   <= 8'd255;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         draw_level_ff   <= draw_level_in;
      end
   end

   lsr_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_col (req_start_col),
      .req_start_row (req_start_row),
      .req_end_col   (req_end_col),
      .req_end_row   (req_end_row),
      .image_width   (image_width_ff),
      .image_height  (image_height_ff),
      .queue_full    (queue_full),
      .push          (push)
   );

   lsr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   lsr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .draw_level      (draw_level_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_pixel_level (rsp_pixel_level),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

### test/tb_top.sv
// self-checking testbench for the rasterizer core: directed and random segments and register settings
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM       = 64;
   localparam int ADDR_W        = lsr_pkg::ADDR_W;
   localparam int DATA_W        = lsr_pkg::DATA_W;
   localparam int IDLE_PCT      = 36;
   localparam int SETTLE_CYCLES = 100;
   localparam int STUCK_LIMIT   = 5000;
   localparam int PHASES        = 9;
   localparam int PHASE_ITEMS   = 48;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [5:0] col;
      logic [5:0] row;
      logic [7:0] level;
      logic       last;
   } pixel_write_type;

   class line_pixel_checker;
      pixel_write_type pending_pixels[$];
      int              img_width  = 64;
      int              img_height = 64;
      logic [7:0]      gray_level = 8'd255;
      int              mismatches = 0;

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            lsr_pkg::REG_IMAGE_WIDTH:  img_width  = int'(value[6:0]);
            lsr_pkg::REG_IMAGE_HEIGHT: img_height = int'(value[6:0]);
            lsr_pkg::REG_DRAW_LEVEL:   gray_level = value[7:0];
            default: ;
         endcase
      endfunction

      function bit on_grid(int c, int size);
         int lim;
         lim = (size > MAX_DIM) ? MAX_DIM : size;
         return (c >= 0) && (c < lim);
      endfunction

      function void note_segment(logic signed [7:0] sc, logic signed [7:0] sr,
                                 logic signed [7:0] ec, logic signed [7:0] er);
         int c0, r0, c1, r1, adc, adr;
         int maj0, min0, dmaj, dmin, num, den, mn;
         bit step_col;
         pixel_write_type px;
         c0 = sc;
         r0 = sr;
         c1 = ec;
         r1 = er;
         if (!on_grid(c0, img_width) || !on_grid(c1, img_width) ||
             !on_grid(r0, img_height) || !on_grid(r1, img_height))
            return;
         adc = (c1 >= c0) ? c1 - c0 : c0 - c1;
         adr = (r1 >= r0) ? r1 - r0 : r0 - r1;
         step_col = (adr <= adc);
         if (step_col) begin
            if (c0 <= c1) begin
               maj0 = c0; min0 = r0; dmaj = c1 - c0; dmin = r1 - r0;
            end else begin
               maj0 = c1; min0 = r1; dmaj = c0 - c1; dmin = r0 - r1;
            end
         end else begin
            if (r0 <= r1) begin
               maj0 = r0; min0 = c0; dmaj = r1 - r0; dmin = c1 - c0;
            end else begin
               maj0 = r1; min0 = c1; dmaj = r0 - r1; dmin = c0 - c1;
            end
         end
         for (int t = 0; t <= dmaj; t++) begin
            mn = min0;
            if (dmaj > 0) begin
               // minor offset rounded half up: floor((2*t*dmin + dmaj) / (2*dmaj))
               num = 2 * t * dmin + dmaj;
               den = 2 * dmaj;
               mn += (num >= 0) ? num / den : -((-num + den - 1) / den);
            end
            px.col   = step_col ? 6'(maj0 + t) : 6'(mn);
            px.row   = step_col ? 6'(mn) : 6'(maj0 + t);
            px.level = gray_level;
            px.last  = (t == dmaj);
            pending_pixels.push_back(px);
         end
      endfunction

      function void check_pixel(pixel_write_type got);
         pixel_write_type want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pixel: col %0d row %0d level %0d last %0b",
                        got.col, got.row, got.level, got.last);
            return;
         end
         want = pending_pixels.pop_front();
         if (got.col !== want.col || got.row !== want.row ||
             got.level !== want.level || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"pixel mismatch: expected col %0d row %0d level %0d last %0b,",
                         " got col %0d row %0d level %0d last %0b"},
                        want.col, want.row, want.level, want.last,
                        got.col, got.row, got.level, got.last);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_W-1:0]     paddr = '0;
   logic [DATA_W-1:0]     pwdata = '0;
   logic [DATA_W-1:0]     prdata;
   logic                  pready;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [7:0]     req_start_col = '0;
   logic signed [7:0]     req_start_row = '0;
   logic signed [7:0]     req_end_col = '0;
   logic signed [7:0]     req_end_row = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [5:0]            rsp_pixel_col;
   logic [5:0]            rsp_pixel_row;
   logic [7:0]            rsp_pixel_level;
   logic                  rsp_last_pixel;

   line_pixel_checker raster_ref;
   bit                calm = 1'b0;
   int                stuck_cycles = 0;

   int phase_width[PHASES]  = '{64, 1, 127, 0, 37, 64, 2, -1, -1};
   int phase_height[PHASES] = '{64, 1, 127, 40, 20, 1, 64, -1, -1};
   int phase_level[PHASES]  = '{255, 0, -1, -1, 0, -1, 255, -1, -1};

   line_segment_rasterizer_core #(.MAX_DIM(MAX_DIM)) u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         raster_ref.check_pixel('{rsp_pixel_col, rsp_pixel_row, rsp_pixel_level,
                                  rsp_last_pixel});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pwrite && pready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      raster_ref.set_register(idx, value);
   endtask

   task automatic send_segment(input logic signed [7:0] sc, input logic signed [7:0] sr,
                               input logic signed [7:0] ec, input logic signed [7:0] er);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < IDLE_PCT);
      end
      req_valid     <= 1'b1;
      req_start_col <= sc;
      req_start_row <= sr;
      req_end_col   <= ec;
      req_end_row   <= er;
      do @(posedge clock); while (req_stall);
      raster_ref.note_segment(sc, sr, ec, er);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (raster_ref.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [7:0] pick_coord(int size);
      int lim;
      lim = (size > MAX_DIM) ? MAX_DIM : size;
      if (lim == 0 || $urandom_range(0, 99) < 12)
         return 8'($urandom);
      return 8'($urandom_range(0, lim - 1));
   endfunction

   initial begin
      int w, h, lvl, items;
      logic signed [7:0] sc, sr, ec, er;
      raster_ref = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed segments under the reset settings
      send_segment(0, 0, 0, 0);
      send_segment(63, 63, 63, 63);
      send_segment(0, 0, 63, 63);
      send_segment(63, 0, 0, 63);
      send_segment(0, 5, 63, 5);
      send_segment(63, 9, 0, 9);
      send_segment(7, 63, 7, 0);
      send_segment(40, 0, 40, 63);
      send_segment(3, 0, 10, 63);
      send_segment(10, 63, 3, 0);
      send_segment(0, 10, 63, 3);
      send_segment(0, 0, 2, 1);
      send_segment(0, 1, 2, 0);
      send_segment(5, 5, 8, 6);
      send_segment(-1, 0, 0, 0);
      send_segment(0, 0, 64, 0);
      send_segment(-128, -128, 127, 127);
      send_segment(127, 127, 127, 127);
      send_segment(0, -128, 0, 0);
      send_segment(0, 0, 0, 127);
      send_segment(62, 1, 1, 62);
      send_segment(-86, 85, 42, -43);
      drain_and_settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         w   = (phase_width[ph] < 0) ? $urandom_range(1, MAX_DIM) : phase_width[ph];
         h   = (phase_height[ph] < 0) ? $urandom_range(1, MAX_DIM) : phase_height[ph];
         lvl = (phase_level[ph] < 0) ? $urandom_range(0, 255) : phase_level[ph];
         write_reg(lsr_pkg::REG_IMAGE_WIDTH, ($urandom & 32'hFFFF_FF80) | 32'(w));
         write_reg(lsr_pkg::REG_IMAGE_HEIGHT, ($urandom & 32'hFFFF_FF80) | 32'(h));
         write_reg(lsr_pkg::REG_DRAW_LEVEL, ($urandom & 32'hFFFF_FF00) | 32'(lvl));
         if (ph == 2 || ph == 7)
            write_reg(REG_UNUSED, $urandom);
         calm  = (ph == 4);
         items = (w == 0 || h == 0) ? 10 : PHASE_ITEMS;
         for (int i = 0; i < items; i++) begin
            sc = pick_coord(w);
            sr = pick_coord(h);
            if ($urandom_range(0, 99) < 35) begin
               ec = sc + 8'($urandom_range(0, 8) - 4);
               er = sr + 8'($urandom_range(0, 8) - 4);
            end else begin
               ec = pick_coord(w);
               er = pick_coord(h);
            end
            send_segment(sc, sr, ec, er);
         end
         drain_and_settle();
         calm = 1'b0;
      end

      if (raster_ref.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
hdl/lsr_pkg.sv
hdl/lsr_front.sv
hdl/lsr_queue.sv
hdl/lsr_back.sv
hdl/line_segment_rasterizer_core.sv
test/tb_top.sv
